@@ rtl/jpe_pkg.sv @@
// ---------------------------------------------------------------------------
// jpe_pkg
// Shared types, constants and helpers of the Jacobi polynomial evaluator.
// ---------------------------------------------------------------------------
package jpe_pkg;

   localparam int MAX_DEGREE    = 15;
   localparam int FRACTION_BITS = 12;
   localparam int PAR_FRAC      = 12;

   localparam int DEG_W  = 4;
   localparam int VAL_W  = 32;
   localparam int X_W    = 16;
   localparam int PAR_W  = 16;
   localparam int CIDX_W = 2;
   localparam int K_W    = 5;
   localparam int C_W    = K_W + PAR_FRAC + 2;
   localparam int PA_W   = PAR_W + 2;
   localparam int SQ_W   = 32;
   localparam int MX_W   = 40;
   localparam int MY_W   = 34;
   localparam int MP_W   = MX_W + MY_W;
   localparam int INNER_W = 38;
   localparam int CA_W   = 34;
   localparam int NUM_W  = 67;
   localparam int DEN_W  = 30;
   localparam int Q_W    = NUM_W + 1;

   localparam logic signed [VAL_W-1:0] VAL_ONE = VAL_W'(1) << FRACTION_BITS;
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [CIDX_W-1:0] {
      CSR_ALPHA,
      CSR_BETA,
      CSR_DEGREE
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_SQA,
      OP_SQB,
      OP_T1,
      OP_INNER,
      OP_CA,
      OP_T3,
      OP_CB,
      OP_T4,
      OP_DD,
      OP_U1,
      OP_U2,
      OP_P1
   } mul_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT
   } state_type;

   typedef struct packed {
      logic             load_x;
      logic             mul_start;
      mul_op_type       mul_op;
      logic             div_start;
      logic             emit_load;
      logic [DEG_W-1:0] step;
      logic             last;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
   } dp_status_type;

   function automatic mul_op_type next_op(input mul_op_type op);
      mul_op_type nxt;
      unique case (op)
         OP_SQA:   nxt = OP_SQB;
         OP_SQB:   nxt = OP_T1;
         OP_T1:    nxt = OP_INNER;
         OP_INNER: nxt = OP_CA;
         OP_CA:    nxt = OP_T3;
         OP_T3:    nxt = OP_CB;
         OP_CB:    nxt = OP_T4;
         OP_T4:    nxt = OP_DD;
         OP_DD:    nxt = OP_U1;
         OP_U1:    nxt = OP_U2;
         default:  nxt = OP_SQA;
      endcase
      return nxt;
   endfunction

   function automatic logic signed [C_W-1:0] cval(input logic [K_W-1:0] k,
                                                  input logic signed [PAR_W:0] s);
      return $signed({2'b00, k, {PAR_FRAC{1'b0}}}) + C_W'(s);
   endfunction

   function automatic logic signed [MP_W-1:0] rnd_shift(input logic signed [MP_W-1:0] v,
                                                        input int unsigned sh);
      logic signed [MP_W-1:0] half;
      half = $signed(MP_W'(1) << (sh - 1));
      return (v + half) >>> sh;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [MP_W-1:0] v);
      logic [MP_W-VAL_W:0] hi;
      logic signed [VAL_W-1:0] r;
      hi = v[MP_W-1:VAL_W-1];
      if ((&hi) || !(|hi)) begin
         r = v[VAL_W-1:0];
      end else if (v[MP_W-1]) begin
         r = VAL_MIN;
      end else begin
         r = VAL_MAX;
      end
      return r;
   endfunction

endpackage

@@ rtl/jpe_if.sv @@
// ---------------------------------------------------------------------------
// jpe channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface jpe_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [jpe_pkg::X_W-1:0]       abscissa;
   modport source (output valid, abscissa, input ready);
   modport sink (input valid, abscissa, output ready);
endinterface

interface jpe_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [jpe_pkg::DEG_W-1:0]            poly_degree;
   logic signed [jpe_pkg::VAL_W-1:0]     poly_value;
   logic                                 last;
   modport source (output valid, poly_degree, poly_value, last, input ready);
   modport sink (input valid, poly_degree, poly_value, last, output ready);
endinterface

interface jpe_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [jpe_pkg::CIDX_W-1:0]           index;
   logic [jpe_pkg::PAR_W-1:0]            data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/jpe_mul.sv @@
// ---------------------------------------------------------------------------
// jpe_mul
// Shift-add signed multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module jpe_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [jpe_pkg::MX_W-1:0]     op_x,
   input  logic signed [jpe_pkg::MY_W-1:0]     op_y,
   output logic                                done,
   output logic signed [jpe_pkg::MP_W-1:0]     product
);

   localparam int CNT_W = $clog2(jpe_pkg::MY_W);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(jpe_pkg::MY_W - 1);

   logic signed [jpe_pkg::MP_W-1:0] mcand_ff, mcand_in;
   logic signed [jpe_pkg::MP_W-1:0] acc_ff, acc_in;
   logic [jpe_pkg::MY_W-1:0]        mplier_ff, mplier_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = jpe_pkg::MP_W'(op_x);
         mplier_in = op_y;
         acc_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = (cnt_ff == LAST_CNT) ? acc_ff - mcand_ff : acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ rtl/jpe_div.sv @@
// ---------------------------------------------------------------------------
// jpe_div
// Restoring divider: rounded signed quotient, saturated to the value width.
// ---------------------------------------------------------------------------
module jpe_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [jpe_pkg::NUM_W-1:0]     num,
   input  logic signed [jpe_pkg::DEN_W-1:0]     den,
   output logic                                 done,
   output logic signed [jpe_pkg::VAL_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(jpe_pkg::Q_W);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(jpe_pkg::Q_W - 1);

   logic [jpe_pkg::Q_W-1:0]   q_ff, q_in;
   logic [jpe_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [jpe_pkg::DEN_W-1:0] dmag_ff, dmag_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   logic                      zero_ff, zero_in;
   logic                      nsign_ff, nsign_in;
   logic                      nzero_ff, nzero_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic [jpe_pkg::NUM_W-1:0] nmag;
   logic [jpe_pkg::DEN_W-1:0] dmag;
   logic [jpe_pkg::DEN_W:0]   trial;
   logic                      ge;
   logic                      big;

   always_comb begin
      nmag  = num[jpe_pkg::NUM_W-1] ? jpe_pkg::NUM_W'(-num) : jpe_pkg::NUM_W'(num);
      dmag  = den[jpe_pkg::DEN_W-1] ? jpe_pkg::DEN_W'(-den) : jpe_pkg::DEN_W'(den);
      trial = {rem_ff, q_ff[jpe_pkg::Q_W-1]};
      ge    = (trial >= {1'b0, dmag_ff});

      q_in     = q_ff;
      rem_in   = rem_ff;
      dmag_in  = dmag_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      nsign_in = nsign_ff;
      nzero_in = nzero_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         nsign_in = num[jpe_pkg::NUM_W-1];
         nzero_in = |num;
         neg_in   = num[jpe_pkg::NUM_W-1] ^ den[jpe_pkg::DEN_W-1];
         dmag_in  = dmag;
         rem_in   = '0;
         cnt_in   = '0;
         q_in     = jpe_pkg::Q_W'(nmag) + jpe_pkg::Q_W'(dmag >> 1);
         if (den == '0) begin
            zero_in = 1'b1;
            done_in = 1'b1;
         end else begin
            zero_in = 1'b0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? jpe_pkg::DEN_W'(trial - {1'b0, dmag_ff}) : trial[jpe_pkg::DEN_W-1:0];
         q_in   = {q_ff[jpe_pkg::Q_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      big = |q_ff[jpe_pkg::Q_W-1:jpe_pkg::VAL_W-1];
      if (zero_ff) begin
         quotient = nsign_ff ? jpe_pkg::VAL_MIN : (nzero_ff ? jpe_pkg::VAL_MAX : '0);
      end else if (neg_ff) begin
         quotient = big ? jpe_pkg::VAL_MIN : $signed(~q_ff[jpe_pkg::VAL_W-1:0] + 1'b1);
      end else begin
         quotient = big ? jpe_pkg::VAL_MAX : $signed(q_ff[jpe_pkg::VAL_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      dmag_ff  <= dmag_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      nsign_ff <= nsign_in;
      nzero_ff <= nzero_in;
   end

   assign done = done_ff;

endmodule

@@ rtl/jpe_datapath.sv @@
// ---------------------------------------------------------------------------
// jpe_datapath
// Recurrence coefficients, shared multiplier and divider, result register.
// ---------------------------------------------------------------------------
module jpe_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  jpe_pkg::dp_cmd_type                  cmd,
   output jpe_pkg::dp_status_type               status,
   input  logic signed [jpe_pkg::PAR_W-1:0]     alpha,
   input  logic signed [jpe_pkg::PAR_W-1:0]     beta,
   input  logic signed [jpe_pkg::X_W-1:0]       abscissa,
   output logic [jpe_pkg::DEG_W-1:0]            poly_degree,
   output logic signed [jpe_pkg::VAL_W-1:0]     poly_value,
   output logic                                 last
);

   logic signed [jpe_pkg::X_W-1:0]     x_ff;
   logic signed [jpe_pkg::SQ_W-1:0]    sq_ff;
   logic signed [jpe_pkg::MX_W-1:0]    t_ff;
   logic signed [jpe_pkg::INNER_W-1:0] inner_ff;
   logic signed [jpe_pkg::CA_W-1:0]    ca_ff;
   logic signed [jpe_pkg::CA_W-1:0]    cb_ff;
   logic signed [jpe_pkg::DEN_W-1:0]   dd_ff;
   logic signed [jpe_pkg::NUM_W-1:0]   u_ff;
   logic signed [jpe_pkg::VAL_W-1:0]   p_old_ff;
   logic signed [jpe_pkg::VAL_W-1:0]   p_new_ff;
   logic [jpe_pkg::DEG_W-1:0]          deg_ff;
   logic signed [jpe_pkg::VAL_W-1:0]   val_ff;
   logic                               last_ff;

   logic signed [jpe_pkg::PAR_W:0]     s;
   logic signed [jpe_pkg::PAR_W:0]     amb;
   logic [jpe_pkg::K_W-1:0]            k2, k2m1, k2m2, ki;
   logic [jpe_pkg::DEG_W-1:0]          stepm1;
   logic signed [jpe_pkg::C_W-1:0]     c2, c2m1, c2m2, ci;
   logic signed [jpe_pkg::PA_W-1:0]    pa, pb, p1x;
   logic signed [jpe_pkg::MX_W-1:0]    op_x;
   logic signed [jpe_pkg::MY_W-1:0]    op_y;
   logic signed [jpe_pkg::MP_W-1:0]    prod;
   logic signed [jpe_pkg::MP_W-1:0]    inner_sum;
   logic signed [jpe_pkg::MP_W-1:0]    q27;
   logic signed [jpe_pkg::VAL_W-1:0]   div_q;
   logic                               mul_done;
   logic                               div_done;

   function automatic logic signed [jpe_pkg::PAR_W:0] PAR_W_EXT(
      input logic signed [jpe_pkg::PAR_W-1:0] v);
      return (jpe_pkg::PAR_W + 1)'(v);
   endfunction

   always_comb begin
      s      = PAR_W_EXT(alpha) + PAR_W_EXT(beta);
   end

   always_comb begin
      amb    = PAR_W_EXT(alpha) - PAR_W_EXT(beta);
      k2     = {cmd.step, 1'b0};
      k2m1   = k2 - jpe_pkg::K_W'(1);
      k2m2   = k2 - jpe_pkg::K_W'(2);
      ki     = {1'b0, cmd.step};
      stepm1 = cmd.step - jpe_pkg::DEG_W'(1);
      c2     = jpe_pkg::cval(k2, s);
      c2m1   = jpe_pkg::cval(k2m1, s);
      c2m2   = jpe_pkg::cval(k2m2, s);
      ci     = jpe_pkg::cval(ki, s);
      pa     = jpe_pkg::PA_W'($signed({1'b0, stepm1, {jpe_pkg::PAR_FRAC{1'b0}}}))
               + jpe_pkg::PA_W'(alpha);
      pb     = jpe_pkg::PA_W'($signed({1'b0, stepm1, {jpe_pkg::PAR_FRAC{1'b0}}}))
               + jpe_pkg::PA_W'(beta);
      p1x    = jpe_pkg::PA_W'(s) + jpe_pkg::PA_W'(2 << jpe_pkg::PAR_FRAC);
   end

   always_comb begin
      case (cmd.mul_op)
         jpe_pkg::OP_SQA: begin
            op_x = jpe_pkg::MX_W'(alpha);
            op_y = jpe_pkg::MY_W'(alpha);
         end
         jpe_pkg::OP_SQB: begin
            op_x = jpe_pkg::MX_W'(beta);
            op_y = jpe_pkg::MY_W'(beta);
         end
         jpe_pkg::OP_T1: begin
            op_x = jpe_pkg::MX_W'(c2m2);
            op_y = jpe_pkg::MY_W'(c2);
         end
         jpe_pkg::OP_INNER: begin
            op_x = t_ff;
            op_y = jpe_pkg::MY_W'(x_ff);
         end
         jpe_pkg::OP_CA: begin
            op_x = jpe_pkg::MX_W'(inner_ff);
            op_y = jpe_pkg::MY_W'(c2m1);
         end
         jpe_pkg::OP_T3: begin
            op_x = jpe_pkg::MX_W'(pa);
            op_y = jpe_pkg::MY_W'(pb);
         end
         jpe_pkg::OP_CB: begin
            op_x = t_ff;
            op_y = jpe_pkg::MY_W'(c2);
         end
         jpe_pkg::OP_T4: begin
            op_x = jpe_pkg::MX_W'($signed({1'b0, k2}));
            op_y = jpe_pkg::MY_W'(ci);
         end
         jpe_pkg::OP_DD: begin
            op_x = t_ff;
            op_y = jpe_pkg::MY_W'(c2m2);
         end
         jpe_pkg::OP_U1: begin
            op_x = jpe_pkg::MX_W'(ca_ff);
            op_y = jpe_pkg::MY_W'(p_new_ff);
         end
         jpe_pkg::OP_U2: begin
            op_x = jpe_pkg::MX_W'(cb_ff);
            op_y = jpe_pkg::MY_W'(p_old_ff);
         end
         jpe_pkg::OP_P1: begin
            op_x = jpe_pkg::MX_W'(p1x);
            op_y = jpe_pkg::MY_W'(x_ff);
         end
         default: begin
            op_x = '0;
            op_y = '0;
         end
      endcase
   end

   jpe_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_x    (op_x),
      .op_y    (op_y),
      .done    (mul_done),
      .product (prod)
   );

   jpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (u_ff),
      .den      (dd_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign inner_sum = prod + (jpe_pkg::MP_W'(sq_ff) <<< 14);
   assign q27       = prod + (jpe_pkg::MP_W'(amb) <<< 14);

   always_ff @(posedge clock) begin
      if (cmd.load_x) begin
         x_ff <= abscissa;
      end
      if (mul_done) begin
         case (cmd.mul_op)
            jpe_pkg::OP_SQA:   sq_ff <= jpe_pkg::SQ_W'(prod);
            jpe_pkg::OP_SQB:   sq_ff <= sq_ff - jpe_pkg::SQ_W'(prod);
            jpe_pkg::OP_T1,
            jpe_pkg::OP_T3,
            jpe_pkg::OP_T4:    t_ff <= jpe_pkg::MX_W'(prod);
            jpe_pkg::OP_INNER: inner_ff <= jpe_pkg::INNER_W'(jpe_pkg::rnd_shift(inner_sum, 14));
            jpe_pkg::OP_CA:    ca_ff <= jpe_pkg::CA_W'(jpe_pkg::rnd_shift(prod, 24));
            jpe_pkg::OP_CB:    cb_ff <= jpe_pkg::CA_W'(jpe_pkg::rnd_shift(prod, 23));
            jpe_pkg::OP_DD:    dd_ff <= jpe_pkg::DEN_W'(jpe_pkg::rnd_shift(prod,
                                                                     jpe_pkg::PAR_FRAC));
            jpe_pkg::OP_U1:    u_ff <= jpe_pkg::NUM_W'(prod);
            jpe_pkg::OP_U2:    u_ff <= u_ff - jpe_pkg::NUM_W'(prod);
            jpe_pkg::OP_P1: begin
               p_old_ff <= jpe_pkg::VAL_ONE;
               p_new_ff <= jpe_pkg::sat_val(jpe_pkg::rnd_shift(q27,
                                                            27 - jpe_pkg::FRACTION_BITS));
            end
            default: ;
         endcase
      end
      if (div_done) begin
         p_old_ff <= p_new_ff;
         p_new_ff <= div_q;
      end
      if (cmd.emit_load) begin
         deg_ff  <= cmd.step;
         val_ff  <= (cmd.step == '0) ? jpe_pkg::VAL_ONE : p_new_ff;
         last_ff <= cmd.last;
      end
   end

   assign status.mul_done = mul_done;
   assign status.div_done = div_done;
   assign poly_degree     = deg_ff;
   assign poly_value      = val_ff;
   assign last            = last_ff;

endmodule

@@ rtl/jpe_ctrl.sv @@
// ---------------------------------------------------------------------------
// jpe_ctrl
// Sequencer: degree loop, multiply/divide operation order, result handshake.
// ---------------------------------------------------------------------------
module jpe_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [jpe_pkg::DEG_W-1:0]     degree,
   output jpe_pkg::dp_cmd_type           cmd,
   input  jpe_pkg::dp_status_type        status
);

   jpe_pkg::state_type         state_ff, state_in;
   jpe_pkg::mul_op_type        op_ff, op_in;
   logic [jpe_pkg::DEG_W-1:0]  step_ff, step_in;
   logic [jpe_pkg::DEG_W-1:0]  n_ff, n_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       emit_ok;

   assign emit_ok = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      step_in      = step_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         jpe_pkg::ST_IDLE: begin
            if (req_valid) begin
               n_in     = (degree > jpe_pkg::DEG_W'(jpe_pkg::MAX_DEGREE)) ?
                          jpe_pkg::DEG_W'(jpe_pkg::MAX_DEGREE) : degree;
               step_in  = '0;
               state_in = jpe_pkg::ST_EMIT;
            end
         end
         jpe_pkg::ST_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               if (step_ff == n_ff) begin
                  state_in = jpe_pkg::ST_IDLE;
               end else begin
                  step_in  = step_ff + jpe_pkg::DEG_W'(1);
                  op_in    = (step_ff == '0) ? jpe_pkg::OP_P1 : jpe_pkg::OP_SQA;
                  state_in = jpe_pkg::ST_MUL_GO;
               end
            end
         end
         jpe_pkg::ST_MUL_GO: state_in = jpe_pkg::ST_MUL_WAIT;
         jpe_pkg::ST_MUL_WAIT: begin
            if (status.mul_done) begin
               if (op_ff == jpe_pkg::OP_P1) begin
                  state_in = jpe_pkg::ST_EMIT;
               end else if (op_ff == jpe_pkg::OP_U2) begin
                  state_in = jpe_pkg::ST_DIV_GO;
               end else begin
                  op_in    = jpe_pkg::next_op(op_ff);
                  state_in = jpe_pkg::ST_MUL_GO;
               end
            end
         end
         jpe_pkg::ST_DIV_GO: state_in = jpe_pkg::ST_DIV_WAIT;
         jpe_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = jpe_pkg::ST_EMIT;
            end
         end
         default: state_in = jpe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == jpe_pkg::ST_IDLE);
      cmd.load_x    = (state_ff == jpe_pkg::ST_IDLE) && req_valid;
      cmd.mul_start = (state_ff == jpe_pkg::ST_MUL_GO);
      cmd.mul_op    = op_ff;
      cmd.div_start = (state_ff == jpe_pkg::ST_DIV_GO);
      cmd.emit_load = (state_ff == jpe_pkg::ST_EMIT) && emit_ok;
      cmd.step      = step_ff;
      cmd.last      = (step_ff == n_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jpe_pkg::ST_IDLE;
         op_ff        <= jpe_pkg::OP_SQA;
         step_ff      <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> state_ff == jpe_pkg::ST_MUL_WAIT)
      else $error("multiply completion outside wait state");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == jpe_pkg::ST_DIV_WAIT)
      else $error("divide completion outside wait state");

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff != jpe_pkg::ST_IDLE |-> step_ff <= n_ff)
      else $error("degree counter beyond highest degree");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load && cmd.last) |=> (state_ff == jpe_pkg::ST_IDLE) && rsp_valid_ff)
      else $error("final result did not end the transaction");

endmodule

@@ rtl/jacobi_polynomial_evaluator.sv @@
// ---------------------------------------------------------------------------
// jacobi_polynomial_evaluator
// Emits P_0(x) .. P_n(x) of the Jacobi family by the three-term recurrence.
//
//   channel  dir  payload                          transaction
//   req_ch   in   abscissa                         one point x
//   rsp_ch   out  poly_degree, poly_value, last    one value per degree
//   csr_ch   in   index, data                      one register write
//
// P0 leaves first, with no arithmetic, and P1 follows after one multiply; each
// higher degree takes eleven multiplies on the one shift-add multiplier
// plus one division on the restoring divider.
// A stalled response holds the sequencer; the next request is taken once the
// last value is in the output register. Synchronous reset restores defaults.
// ---------------------------------------------------------------------------
module jacobi_polynomial_evaluator (
   input logic       clock,
   input logic       reset,
   jpe_req_if.sink   req_ch,
   jpe_rsp_if.source rsp_ch,
   jpe_csr_if.sink   csr_ch
);

   logic signed [jpe_pkg::PAR_W-1:0] alpha_ff;
   logic signed [jpe_pkg::PAR_W-1:0] beta_ff;
   logic [jpe_pkg::DEG_W-1:0]        degree_ff;

   jpe_pkg::dp_cmd_type    cmd;
   jpe_pkg::dp_status_type status;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= jpe_pkg::PAR_W'(1 << jpe_pkg::PAR_FRAC);
         beta_ff   <= jpe_pkg::PAR_W'(1 << jpe_pkg::PAR_FRAC);
         degree_ff <= jpe_pkg::DEG_W'(10);
      end else if (csr_ch.valid) begin
         unique case (jpe_pkg::csr_index_type'(csr_ch.index))
            jpe_pkg::CSR_ALPHA:  alpha_ff  <= $signed(csr_ch.data);
            jpe_pkg::CSR_BETA:   beta_ff   <= $signed(csr_ch.data);
            jpe_pkg::CSR_DEGREE: degree_ff <= csr_ch.data[jpe_pkg::DEG_W-1:0];
            default: ;
         endcase
      end
   end

   jpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .degree    (degree_ff),
      .cmd       (cmd),
      .status    (status)
   );

   jpe_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .alpha       (alpha_ff),
      .beta        (beta_ff),
      .abscissa    (req_ch.abscissa),
      .poly_degree (rsp_ch.poly_degree),
      .poly_value  (rsp_ch.poly_value),
      .last        (rsp_ch.last)
   );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Jacobi polynomial evaluator testbench
// Drives abscissa transactions under changing alpha, beta and degree
// settings, predicts every P_k(x) with an integer fixed-point recurrence and
// checks each response transaction, in order, field by field.
// ---------------------------------------------------------------------------
module tb_top;

   localparam logic [jpe_pkg::CIDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 30000000;
   localparam int FREEZE_CYCLES = 2500;

   typedef struct packed {
      logic [jpe_pkg::DEG_W-1:0]        degree;
      logic signed [jpe_pkg::VAL_W-1:0] value;
      logic                             last;
   } poly_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jpe_req_if req_bus ();
   jpe_rsp_if rsp_bus ();
   jpe_csr_if csr_bus ();

   jacobi_polynomial_evaluator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   logic signed [jpe_pkg::PAR_W-1:0] alpha_cfg = 16'sd4096;
   logic signed [jpe_pkg::PAR_W-1:0] beta_cfg  = 16'sd4096;
   logic [jpe_pkg::DEG_W-1:0]        degree_cfg = 4'd10;

   logic signed [jpe_pkg::X_W-1:0] pending_x[$];
   poly_result_type                expected_values[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  recv_stall = 0;
   int  freeze_left = 0;
   int  freeze_req = 0;
   int  freeze_seen = 0;
   int  items_sent = 0;
   bit  tx_idle = 1'b0;
   bit  rx_idle = 1'b0;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic longint round_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint divide_rounded(longint num, longint den);
      longint nm, dm, q;
      if (den == 0) begin
         if (num > 0) return 64'sd2147483647;
         if (num < 0) return -64'sd2147483648;
         return 0;
      end
      nm = (num < 0) ? -num : num;
      dm = (den < 0) ? -den : den;
      q = (nm + dm / 2) / dm;
      if (q > (longint'(1) << 32)) q = longint'(1) << 32;
      return sat32(((num < 0) != (den < 0)) ? -q : q);
   endfunction

   function automatic void push_value(int k, longint v, bit last);
      poly_result_type r;
      r.degree = k[jpe_pkg::DEG_W-1:0];
      r.value  = v[jpe_pkg::VAL_W-1:0];
      r.last   = last;
      expected_values.insert(expected_values.size(), r);
   endfunction

   // Recurrence for one abscissa under the current register settings.
   function automatic void predict_series(logic signed [jpe_pkg::X_W-1:0] x_in);
      longint a, b, s, x, p0, p1, q27, c2m2, c2m1, c2, ci, inner, ca, cb, dd, num, p, ii;
      int n;
      a = alpha_cfg;
      b = beta_cfg;
      s = a + b;
      x = x_in;
      n = (degree_cfg > jpe_pkg::MAX_DEGREE) ? jpe_pkg::MAX_DEGREE : degree_cfg;
      p0 = longint'(1) << jpe_pkg::FRACTION_BITS;
      push_value(0, p0, n == 0);
      if (n == 0) return;
      q27 = (a - b) * 16384 + (2 * 4096 + s) * x;
      p1 = sat32(round_shift(q27, 27 - jpe_pkg::FRACTION_BITS));
      push_value(1, p1, n == 1);
      for (int i = 2; i <= n; i++) begin
         ii = i;
         c2m2 = (2 * ii - 2) * 4096 + s;
         c2m1 = (2 * ii - 1) * 4096 + s;
         c2 = 2 * ii * 4096 + s;
         ci = ii * 4096 + s;
         inner = round_shift(c2m2 * c2 * x + (a * a - b * b) * 16384, 14);
         ca = round_shift(c2m1 * inner, 24);
         cb = round_shift(2 * ((ii - 1) * 4096 + a) * ((ii - 1) * 4096 + b) * c2, 24);
         dd = round_shift(2 * ii * ci * c2m2, jpe_pkg::PAR_FRAC);
         num = ca * p1 - cb * p0;
         p = divide_rounded(num, dd);
         push_value(i, p, i == n);
         p0 = p1;
         p1 = p;
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s at cycle %0d: got %0d, want %0d", what, cycle_count, got, want);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.abscissa <= '0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_series(req_bus.abscissa);
            send_gap = tx_idle ? $urandom_range(0, 15) : 0;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_x.size() > 0) begin
               req_bus.abscissa <= pending_x.pop_front();
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      poly_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_values.size() == 0) begin
               report_mismatch("unexpected transaction, degree", rsp_bus.poly_degree, -1);
            end else begin
               want = expected_values.pop_front();
               if (rsp_bus.poly_degree !== want.degree)
                  report_mismatch("poly_degree", rsp_bus.poly_degree, want.degree);
               if (rsp_bus.poly_value !== want.value)
                  report_mismatch("poly_value", rsp_bus.poly_value, want.value);
               if (rsp_bus.last !== want.last)
                  report_mismatch("last", rsp_bus.last, want.last);
            end
            recv_stall = rx_idle ? $urandom_range(0, 15) : 0;
         end
         if (freeze_seen != freeze_req) begin
            freeze_seen = freeze_req;
            freeze_left = FREEZE_CYCLES;
         end
         if (freeze_left > 0) begin
            freeze_left--;
            rsp_bus.ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic write_csr(logic [jpe_pkg::CIDX_W-1:0] idx,
                            logic [jpe_pkg::PAR_W-1:0] data);
      @(posedge clock);
      csr_bus.index <= idx;
      csr_bus.data <= data;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         jpe_pkg::CSR_ALPHA:  alpha_cfg = data;
         jpe_pkg::CSR_BETA:   beta_cfg = data;
         jpe_pkg::CSR_DEGREE: degree_cfg = data[jpe_pkg::DEG_W-1:0];
         default:    ;
      endcase
   endtask

   task automatic configure(logic [jpe_pkg::PAR_W-1:0] a, logic [jpe_pkg::PAR_W-1:0] b,
                            int deg);
      write_csr(jpe_pkg::CSR_ALPHA, a);
      write_csr(jpe_pkg::CSR_BETA, b);
      write_csr(jpe_pkg::CSR_DEGREE, jpe_pkg::PAR_W'(deg));
   endtask

   task automatic settle();
      while (pending_x.size() > 0 || req_bus.valid || expected_values.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_x(logic signed [jpe_pkg::X_W-1:0] x);
      pending_x.insert(pending_x.size(), x);
      items_sent++;
   endtask

   task automatic send_random(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) == 0) send_x(jpe_pkg::X_W'($urandom()));
         else send_x(jpe_pkg::X_W'($signed($urandom_range(0, 32768)) - 16384));
      end
   endtask

   function automatic logic [jpe_pkg::PAR_W-1:0] draw_param();
      if ($urandom_range(0, 9) == 0) return jpe_pkg::PAR_W'($urandom());
      return jpe_pkg::PAR_W'($signed($urandom_range(0, 36862)) - 4095);
   endfunction

   initial begin
      int deg;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings, abscissa extremes
      send_x(-16'sd16384); send_x(16'sd16384); send_x(16'sd0); send_x(-16'sd32768);
      send_x(16'sd32767); send_x(16'sd1); send_x(-16'sd1);
      settle();

      // unused register index must change nothing
      write_csr(CSR_UNUSED, 16'h7fff);
      send_x(16'sd8192);
      settle();

      configure(16'sd0, 16'sd0, 0);
      send_x(16'sd5000); send_x(-16'sd16384);
      settle();

      configure(16'sd32767, 16'sd32767, 15);
      send_x(16'sd16384); send_x(-16'sd16384);
      settle();

      // zero divisor: c(2) vanishes
      configure(-16'sd4096, -16'sd4096, 15);
      send_x(16'sd4000); send_x(16'sd0);
      settle();

      configure(-16'sd4095, 16'sd32767, 1);
      send_x(16'sd16384); send_x(-16'sd16384);
      settle();

      configure(-16'sd32768, 16'sd12345, 4);
      send_x(16'sd9000); send_x(-16'sd32768);
      settle();

      // output frozen while requests keep coming
      configure(16'sd2048, -16'sd2048, 2);
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      freeze_req++;
      send_random(24);
      settle();

      while (items_sent < 380) begin
         tx_idle = $urandom_range(0, 2) != 0;
         rx_idle = $urandom_range(0, 2) != 0;
         deg = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 15);
         configure(draw_param(), draw_param(), deg);
         send_random(deg > 3 ? 3 : 25);
         settle();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
